[hdl/assert_macros.svh]
// Assertion helpers shared by the scanner RTL.
// Clocked property checks with and without a reset qualifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge, ignored while reset is asserted
`define STS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define STS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/sts_pkg.sv]
// Shared types, token codes and helper functions of the source token scanner.
// No dependencies; imported by every scanner module.
`timescale 1ns / 1ps

package sts_pkg;

    localparam int HASH_BITS = 10;
    localparam int LINE_BITS = 24;
    localparam int COL_BITS  = 16;
    localparam int KIND_BITS = 9;
    localparam int ERR_BITS  = 3;

    // Token kinds above the byte codes
    localparam logic [8:0] OP_AND_EQ   = 9'd256;
    localparam logic [8:0] OP_OR_EQ    = 9'd257;
    localparam logic [8:0] OP_XOR_EQ   = 9'd258;
    localparam logic [8:0] OP_LSH_EQ   = 9'd259;
    localparam logic [8:0] OP_RSH_EQ   = 9'd260;
    localparam logic [8:0] OP_ADD_EQ   = 9'd261;
    localparam logic [8:0] OP_SUB_EQ   = 9'd262;
    localparam logic [8:0] OP_MUL_EQ   = 9'd263;
    localparam logic [8:0] OP_DIV_EQ   = 9'd264;
    localparam logic [8:0] OP_MOD_EQ   = 9'd265;
    localparam logic [8:0] OP_POW_EQ   = 9'd266;
    localparam logic [8:0] OP_ASSIGN   = 9'd267;
    localparam logic [8:0] OP_LOR      = 9'd268;
    localparam logic [8:0] OP_LAND     = 9'd269;
    localparam logic [8:0] OP_SCOPE    = 9'd270;
    localparam logic [8:0] OP_EQ       = 9'd271;
    localparam logic [8:0] OP_NE       = 9'd272;
    localparam logic [8:0] OP_LE       = 9'd273;
    localparam logic [8:0] OP_GE       = 9'd274;
    localparam logic [8:0] OP_LSH      = 9'd275;
    localparam logic [8:0] OP_RSH      = 9'd276;
    localparam logic [8:0] OP_RECV     = 9'd277;
    localparam logic [8:0] OP_INC      = 9'd278;
    localparam logic [8:0] OP_DEC      = 9'd279;
    localparam logic [8:0] OP_ARROW    = 9'd280;
    localparam logic [8:0] OP_FATARROW = 9'd281;
    localparam logic [8:0] OP_POW      = 9'd282;
    localparam logic [8:0] K_IDENT     = 9'd283;
    localparam logic [8:0] K_INT       = 9'd284;
    localparam logic [8:0] K_REAL      = 9'd285;
    localparam logic [8:0] K_END       = 9'd286;

    // Pair lookup markers
    localparam logic [8:0] PAIR_NONE  = 9'd0;
    localparam logic [8:0] PAIR_THREE = 9'd1;

    // Error codes
    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN   = 3'd1;
    localparam logic [2:0] ERR_MALFORMED = 3'd2;
    localparam logic [2:0] ERR_RADIX     = 3'd3;
    localparam logic [2:0] ERR_DIGIT     = 3'd4;
    localparam logic [2:0] ERR_EOF_NUM   = 3'd5;
    localparam logic [2:0] ERR_LITERAL   = 3'd6;

    // Radix fault codes
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_RADIX = 2'd1;
    localparam logic [1:0] FAULT_DIGIT = 2'd2;

    typedef enum logic [13:0] {
        M_IDLE    = 14'b00000000000001,
        M_COMMENT = 14'b00000000000010,
        M_OP1     = 14'b00000000000100,
        M_OP2     = 14'b00000000001000,
        M_DOT     = 14'b00000000010000,
        M_IDENT   = 14'b00000000100000,
        M_INT     = 14'b00000001000000,
        M_RSEEN   = 14'b00000010000000,
        M_RADIX   = 14'b00000100000000,
        M_FRAC    = 14'b00001000000000,
        M_FRACB   = 14'b00010000000000,
        M_EXPSEEN = 14'b00100000000000,
        M_EXPSIGN = 14'b01000000000000,
        M_EXP     = 14'b10000000000000
    } mode_t;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [63:0]          value;
        logic [HASH_BITS-1:0] bucket;
        logic [ERR_BITS-1:0]  err;
        logic [LINE_BITS-1:0] line;
        logic [COL_BITS-1:0]  col;
    } res_t;

    // One queue entry: all results of one source byte
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } ent_t;

    function automatic res_t mk_res(logic [8:0] kind, logic [63:0] value,
                                    logic [HASH_BITS-1:0] bucket, logic [2:0] err,
                                    logic [LINE_BITS-1:0] line,
                                    logic [COL_BITS-1:0] col);
        res_t r;
        r.kind   = kind;
        r.value  = (err != ERR_OK) ? 64'd0 : value;
        r.bucket = bucket;
        r.err    = err;
        r.line   = line;
        r.col    = col;
        return r;
    endfunction

    function automatic logic [HASH_BITS-1:0] hash_add(logic [HASH_BITS-1:0] h,
                                                      logic [7:0] c);
        logic [31:0] c32;
        logic [31:0] c1;
        logic [31:0] hh;
        c32 = {24'd0, c};
        c1  = c32 ^ (c32 << 6);
        hh  = {{(32-HASH_BITS){1'b0}}, h} + ((c1 << 11) ^ (c1 >> 1));
        hh  = hh ^ ((c32 << 14) + (c32 << 7) + (c32 << 4) + c32);
        return hh[HASH_BITS-1:0];
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"], "_"}) || (c > 8'ha0);
    endfunction

    function automatic logic [7:0] digit_value(logic [7:0] c);
        logic [7:0] d;
        if (is_digit(c)) begin
            d = c - "0";
        end else if (c inside {["a":"z"]}) begin
            d = c - "a" + 8'd10;
        end else if (c inside {["A":"Z"]}) begin
            d = c - "A" + 8'd10;
        end else begin
            d = c;
        end
        return d;
    endfunction

    // Operator code, PAIR_THREE for a possible third char, PAIR_NONE otherwise
    function automatic logic [8:0] op_pair(logic [7:0] f, logic [7:0] c);
        logic [8:0] r;
        r = PAIR_NONE;
        case (f)
            ":": r = (c == ":") ? OP_SCOPE : (c == "=") ? OP_ASSIGN : PAIR_NONE;
            "|": r = (c == "=") ? OP_OR_EQ : (c == "|") ? OP_LOR : PAIR_NONE;
            "&": r = (c == "=") ? OP_AND_EQ : (c == "&") ? OP_LAND : PAIR_NONE;
            "^": r = (c == "=") ? OP_XOR_EQ : PAIR_NONE;
            "*": r = (c == "=") ? OP_MUL_EQ : (c == "*") ? PAIR_THREE : PAIR_NONE;
            "/": r = (c == "=") ? OP_DIV_EQ : PAIR_NONE;
            "%": r = (c == "=") ? OP_MOD_EQ : PAIR_NONE;
            "=": r = (c == "=") ? OP_EQ : (c == ">") ? OP_FATARROW : PAIR_NONE;
            "!": r = (c == "=") ? OP_NE : PAIR_NONE;
            ">": r = (c == "=") ? OP_GE : (c == ">") ? PAIR_THREE : PAIR_NONE;
            "<": r = (c == "=") ? OP_LE : (c == "-") ? OP_RECV :
                     (c == "<") ? PAIR_THREE : PAIR_NONE;
            "+": r = (c == "=") ? OP_ADD_EQ : (c == "+") ? OP_INC : PAIR_NONE;
            "-": r = (c == "=") ? OP_SUB_EQ : (c == "-") ? OP_DEC :
                     (c == ">") ? OP_ARROW : PAIR_NONE;
            default: r = PAIR_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] op_two(logic [7:0] f);
        return (f == "*") ? OP_POW : (f == ">") ? OP_RSH : OP_LSH;
    endfunction

    function automatic logic [8:0] op_three(logic [7:0] f);
        return (f == "*") ? OP_POW_EQ : (f == ">") ? OP_RSH_EQ : OP_LSH_EQ;
    endfunction

endpackage

[hdl/sts_front.sv]
// Scanner front end: classifies each source byte, keeps the token state and
// builds the results of the byte. Depends on sts_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sts_front import sts_pkg::*; #(
    parameter int MAX_TOKEN_CHARS = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_ok,
    input  logic [7:0] ch,
    input  logic       eoi,
    output logic       push,
    output ent_t       ent
);

    localparam int CNT_W = $clog2(MAX_TOKEN_CHARS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_TOKEN_CHARS);
    localparam logic [CNT_W-1:0] CNT_KEEP = CNT_W'(MAX_TOKEN_CHARS - 1);
    localparam logic [LINE_BITS-1:0] LINE_SAT = {LINE_BITS{1'b1}};
    localparam logic [COL_BITS-1:0]  COL_SAT  = {COL_BITS{1'b1}};

    mode_t                mode_reg, mode_next;
    logic [7:0]           pend_reg, pend_next;
    logic [63:0]          acc_reg, acc_next;
    logic [5:0]           radix_reg, radix_next;
    logic [1:0]           fault_reg, fault_next;
    logic [HASH_BITS-1:0] hash_reg, hash_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [COL_BITS-1:0]  col_reg, col_next;
    logic [LINE_BITS-1:0] tline_reg, tline_next;
    logic [COL_BITS-1:0]  tcol_reg, tcol_next;

    logic        a_v, b_v, used, take, kept, an;
    res_t        a_res, b_res;
    logic [8:0]  pair;
    logic [7:0]  dval;
    logic [63:0] mul_k, prod, acc_dec;

    // Shared multiply: decimal or radix weight of the accumulator
    assign kept  = cnt_reg < CNT_KEEP;
    assign an    = is_digit(ch) || is_alpha(ch);
    assign dval  = digit_value(ch);
    assign mul_k = (mode_reg == M_INT) ? 64'd10 : {58'd0, radix_reg};
    assign prod  = acc_reg * mul_k;
    assign acc_dec = prod + {56'd0, dval};

    // Next state and results of one byte
    always_comb begin
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        acc_next   = acc_reg;
        radix_next = radix_reg;
        fault_next = fault_reg;
        hash_next  = hash_reg;
        cnt_next   = cnt_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        a_v   = 1'b0;
        b_v   = 1'b0;
        a_res = '0;
        b_res = '0;
        used  = 1'b0;
        take  = 1'b0;
        pair  = op_pair(pend_reg, ch);

        if (eoi) begin
            // Flush the pending token, then close the stream
            b_v   = 1'b1;
            b_res = mk_res(K_END, 64'd0, '0, ERR_OK, line_reg, col_reg);
            case (mode_reg)
                M_IDLE, M_COMMENT: ;
                M_OP1: begin
                    a_v   = 1'b1;
                    a_res = mk_res({1'b0, pend_reg}, 64'd0, '0, ERR_OK, tline_reg, tcol_reg);
                end
                M_OP2: begin
                    a_v   = 1'b1;
                    a_res = mk_res(op_two(pend_reg), 64'd0, '0, ERR_OK, tline_reg, tcol_reg);
                end
                M_DOT: begin
                    a_v   = 1'b1;
                    a_res = mk_res({1'b0, 8'h2e}, 64'd0, '0, ERR_OK, tline_reg, tcol_reg);
                end
                M_IDENT: begin
                    a_v   = 1'b1;
                    a_res = mk_res(K_IDENT, 64'd0, hash_reg, ERR_OK, tline_reg, tcol_reg);
                end
                default: begin
                    b_res = mk_res(K_END, 64'd0, '0, ERR_EOF_NUM, tline_reg, tcol_reg);
                end
            endcase
            mode_next  = M_IDLE;
            pend_next  = '0;
            acc_next   = '0;
            radix_next = 6'd10;
            fault_next = FAULT_NONE;
            hash_next  = '0;
            cnt_next   = '0;
            line_next  = LINE_BITS'(1);
            col_next   = '0;
            tline_next = LINE_BITS'(1);
            tcol_next  = '0;
        end else begin
            // Continue the token in progress
            case (mode_reg)
                M_IDLE: ;
                M_COMMENT: begin
                    if (ch == 8'h0a) begin
                        mode_next = M_IDLE;
                    end
                    used = 1'b1;
                end
                M_OP1: begin
                    if (pair >= OP_AND_EQ) begin
                        a_v   = 1'b1;
                        a_res = mk_res(pair, 64'd0, '0, ERR_OK, tline_reg, tcol_reg);
                        mode_next = M_IDLE;
                        used = 1'b1;
                    end else if (pair == PAIR_THREE) begin
                        mode_next = M_OP2;
                        used = 1'b1;
                    end else begin
                        a_v   = 1'b1;
                        a_res = mk_res({1'b0, pend_reg}, 64'd0, '0, ERR_OK,
                                       tline_reg, tcol_reg);
                        mode_next = M_IDLE;
                    end
                end
                M_OP2: begin
                    a_v = 1'b1;
                    if (ch == "=") begin
                        a_res = mk_res(op_three(pend_reg), 64'd0, '0, ERR_OK,
                                       tline_reg, tcol_reg);
                        used = 1'b1;
                    end else begin
                        a_res = mk_res(op_two(pend_reg), 64'd0, '0, ERR_OK,
                                       tline_reg, tcol_reg);
                    end
                    mode_next = M_IDLE;
                end
                M_DOT: begin
                    if (is_digit(ch)) begin
                        mode_next = M_FRAC;
                        cnt_next  = CNT_W'(2);
                        used = 1'b1;
                    end else begin
                        a_v   = 1'b1;
                        a_res = mk_res({1'b0, 8'h2e}, 64'd0, '0, ERR_OK, tline_reg, tcol_reg);
                        mode_next = M_IDLE;
                    end
                end
                M_IDENT: begin
                    if (an) begin
                        if (cnt_reg < CNT_MAX) begin
                            hash_next = hash_add(hash_reg, ch);
                            cnt_next  = cnt_reg + 1'b1;
                        end
                        used = 1'b1;
                    end else begin
                        a_v   = 1'b1;
                        a_res = mk_res(K_IDENT, 64'd0, hash_reg, ERR_OK, tline_reg, tcol_reg);
                        mode_next = M_IDLE;
                    end
                end
                default: begin
                    // Number body
                    case (mode_reg)
                        M_INT: begin
                            if (is_digit(ch)) begin
                                if (kept) begin
                                    acc_next = acc_dec;
                                    if (acc_dec > 64'd36) begin
                                        fault_next = FAULT_RADIX;
                                    end
                                end
                                take = 1'b1;
                            end else if (ch == "e" || ch == "E") begin
                                mode_next = M_EXPSEEN;
                                take = 1'b1;
                            end else if (ch == "r" || ch == "R") begin
                                if (fault_reg != FAULT_NONE || acc_reg < 64'd2) begin
                                    fault_next = FAULT_RADIX;
                                end else begin
                                    radix_next = acc_reg[5:0];
                                    fault_next = FAULT_NONE;
                                end
                                acc_next  = '0;
                                mode_next = M_RSEEN;
                                take = 1'b1;
                            end else if (ch == ".") begin
                                mode_next = M_FRAC;
                                take = 1'b1;
                            end
                        end
                        M_RSEEN, M_RADIX, M_FRACB: begin
                            if (an) begin
                                if (kept && fault_reg == FAULT_NONE) begin
                                    if (dval >= {2'b00, radix_reg}) begin
                                        fault_next = FAULT_DIGIT;
                                    end else begin
                                        acc_next = acc_dec;
                                    end
                                end
                                if (mode_reg != M_FRACB) begin
                                    mode_next = M_RADIX;
                                end
                                take = 1'b1;
                            end else if (ch == "." && mode_reg != M_FRACB) begin
                                mode_next = M_FRACB;
                                take = 1'b1;
                            end
                        end
                        M_FRAC: begin
                            if (is_digit(ch)) begin
                                take = 1'b1;
                            end else if (ch == "e" || ch == "E") begin
                                mode_next = M_EXPSEEN;
                                take = 1'b1;
                            end
                        end
                        M_EXPSEEN: begin
                            if (ch == "+" || ch == "-") begin
                                mode_next = M_EXPSIGN;
                                take = 1'b1;
                            end else if (is_digit(ch)) begin
                                mode_next = M_EXP;
                                take = 1'b1;
                            end
                        end
                        default: begin
                            if (is_digit(ch)) begin
                                mode_next = M_EXP;
                                take = 1'b1;
                            end
                        end
                    endcase
                    if (take && cnt_reg < CNT_MAX) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    used = take;
                    // Close the number on a byte that does not belong to it
                    if (!take) begin
                        a_v = 1'b1;
                        mode_next = M_IDLE;
                        case (mode_reg)
                            M_INT: a_res = mk_res(K_INT, acc_reg, '0, ERR_OK,
                                                  tline_reg, tcol_reg);
                            M_RADIX: begin
                                if (fault_reg == FAULT_RADIX) begin
                                    a_res = mk_res(K_INT, 64'd0, '0, ERR_RADIX,
                                                   tline_reg, tcol_reg);
                                end else if (fault_reg == FAULT_DIGIT) begin
                                    a_res = mk_res(K_INT, 64'd0, '0, ERR_DIGIT,
                                                   tline_reg, tcol_reg);
                                end else begin
                                    a_res = mk_res(K_INT, acc_reg, '0, ERR_OK,
                                                   tline_reg, tcol_reg);
                                end
                            end
                            M_FRACB: begin
                                if (fault_reg == FAULT_RADIX) begin
                                    a_res = mk_res(K_INT, 64'd0, '0, ERR_RADIX,
                                                   tline_reg, tcol_reg);
                                end else begin
                                    a_res = mk_res(K_REAL, 64'd0, '0,
                                                   (fault_reg == FAULT_DIGIT) ? ERR_DIGIT
                                                                              : ERR_OK,
                                                   tline_reg, tcol_reg);
                                end
                            end
                            M_FRAC, M_EXP: a_res = mk_res(K_REAL, 64'd0, '0, ERR_OK,
                                                          tline_reg, tcol_reg);
                            default: a_res = mk_res(K_INT, 64'd0, '0, ERR_MALFORMED,
                                                    tline_reg, tcol_reg);
                        endcase
                    end
                end
            endcase

            // Start a new token on a byte not taken above
            if (!used) begin
                tline_next = line_reg;
                tcol_next  = col_reg;
                case (ch) inside
                    8'h0a, 8'h20, 8'h09, 8'h0d, 8'h0b, 8'h0c: ;
                    "#": mode_next = M_COMMENT;
                    8'h22, 8'h27: begin
                        b_v   = 1'b1;
                        b_res = mk_res({1'b0, ch}, 64'd0, '0, ERR_LITERAL, line_reg, col_reg);
                    end
                    "(", ")", "[", "]", "{", "}", ",", ";", "~": begin
                        b_v   = 1'b1;
                        b_res = mk_res({1'b0, ch}, 64'd0, '0, ERR_OK, line_reg, col_reg);
                    end
                    ":", "|", "&", "^", "*", "/", "%", "=", "!", ">", "<", "+", "-": begin
                        pend_next = ch;
                        mode_next = M_OP1;
                    end
                    ".": begin
                        cnt_next  = CNT_W'(1);
                        mode_next = M_DOT;
                    end
                    default: begin
                        if (is_digit(ch)) begin
                            acc_next   = {56'd0, ch - "0"};
                            fault_next = FAULT_NONE;
                            radix_next = 6'd10;
                            cnt_next   = CNT_W'(1);
                            mode_next  = M_INT;
                        end else if (is_alpha(ch)) begin
                            hash_next = hash_add('0, ch);
                            cnt_next  = CNT_W'(1);
                            mode_next = M_IDENT;
                        end else begin
                            b_v   = 1'b1;
                            b_res = mk_res({1'b0, ch}, 64'd0, '0, ERR_UNKNOWN,
                                           line_reg, col_reg);
                        end
                    end
                endcase
            end

            // Advance the source position
            if (ch == 8'h0a) begin
                if (line_reg != LINE_SAT) begin
                    line_next = line_reg + 1'b1;
                end
                col_next = '0;
            end else if (col_reg != COL_SAT) begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    assign push    = in_ok && (a_v || b_v);
    assign ent.two = a_v && b_v;
    assign ent.r0  = a_v ? a_res : b_res;
    assign ent.r1  = b_res;

    // Hold token state, update on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            pend_reg  <= '0;
            acc_reg   <= '0;
            radix_reg <= 6'd10;
            fault_reg <= FAULT_NONE;
            hash_reg  <= '0;
            cnt_reg   <= '0;
            line_reg  <= LINE_BITS'(1);
            col_reg   <= '0;
            tline_reg <= LINE_BITS'(1);
            tcol_reg  <= '0;
        end else if (in_ok) begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            acc_reg   <= acc_next;
            radix_reg <= radix_next;
            fault_reg <= fault_next;
            hash_reg  <= hash_next;
            cnt_reg   <= cnt_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
        end
    end

    `STS_ASSERT(a_eoi_idle, aclk, aresetn, in_ok && eoi |=> mode_reg == M_IDLE && line_reg == LINE_BITS'(1), "state not cleared after end of input")
    `STS_ASSERT(a_eoi_push, aclk, aresetn, in_ok && eoi |-> push, "end of input without a result")
    `STS_ASSERT(a_radix_ok, aclk, aresetn, radix_reg >= 6'd2 && radix_reg <= 6'd36, "active radix out of range")

endmodule

[hdl/sts_fifo.sv]
// Four-entry queue between scanner front end and result back end.
// Depends on sts_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sts_fifo import sts_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  ent_t wdata,
    output logic full,
    input  logic pop,
    output logic nonempty,
    output ent_t rdata
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    ent_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [PTR_W:0]   cnt_reg, cnt_next;

    assign full     = cnt_reg == (PTR_W+1)'(DEPTH);
    assign nonempty = cnt_reg != '0;
    assign rdata    = mem_reg[rptr_reg];
    assign cnt_next = cnt_reg + {{PTR_W{1'b0}}, push} - {{PTR_W{1'b0}}, pop};

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    `STS_ASSERT(a_no_overflow, aclk, aresetn, full |-> !push, "push into full queue")
    `STS_ASSERT(a_no_underflow, aclk, aresetn, !nonempty |-> !pop, "pop from empty queue")
    `STS_ASSERT(a_cnt_range, aclk, aresetn, cnt_reg <= (PTR_W+1)'(DEPTH), "queue count out of range")

endmodule

[hdl/sts_back.sv]
// Result back end: splits each queue entry into one or two results and
// drives the registered result channel. Depends on sts_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sts_back import sts_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic head_v,
    input  ent_t head,
    output logic pop,
    output logic m_valid,
    input  logic m_ready,
    output res_t out_res,
    output logic out_last
);

    logic valid_reg;
    logic second_reg;
    res_t res_reg;
    logic last_reg;
    logic load;

    // Load a new result when the output register is free
    assign load = head_v && (!valid_reg || m_ready);
    assign pop  = load && (second_reg || !head.two);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg  <= 1'b1;
                second_reg <= !second_reg && head.two;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg  <= second_reg ? head.r1 : head.r0;
            last_reg <= second_reg || !head.two;
        end
    end

    assign m_valid  = valid_reg;
    assign out_res  = res_reg;
    assign out_last = last_reg;

    `STS_ASSERT(a_second_holds, aclk, aresetn, second_reg |-> head_v && head.two, "second half without its entry")
    `STS_ASSERT(a_out_held, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(res_reg) && $stable(last_reg), "result changed while waiting")
    `STS_ASSERT(a_pop_valid, aclk, aresetn, pop |-> head_v, "pop without a queue entry")

endmodule

[hdl/source_token_scanner_top.sv]
// Top level of the source token scanner: front end, queue and back end.
// Depends on sts_pkg, sts_front, sts_fifo and sts_back.
`timescale 1ns / 1ps

// Source token scanner. Takes one source byte per cycle on the s_ channel while
// the queue has room and returns tokens on the m_ channel, one result per cycle
// while m_ready holds, m_last marking the final result caused by a byte. A byte
// is taken every cycle while the four-entry result queue has room; a byte that
// yields two tokens holds the output while both are sent, so the sustained rate
// is one byte per cycle as long as tokens average at most one per byte and
// m_ready holds. A result passes through the queue and then the output register
// before it is valid on the m_ channel. No clearing pass follows reset.
// MAX_TOKEN_CHARS caps the characters that feed hash and value.
module source_token_scanner_top import sts_pkg::*; #(
    parameter int MAX_TOKEN_CHARS = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_ch,
    input  logic                 s_end_of_input,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [KIND_BITS-1:0] m_token_kind,
    output logic [63:0]          m_int_value,
    output logic [HASH_BITS-1:0] m_bucket,
    output logic [ERR_BITS-1:0]  m_error_code,
    output logic [LINE_BITS-1:0] m_start_line,
    output logic [COL_BITS-1:0]  m_start_column,
    output logic                 m_last
);

    logic in_ok, push, full, pop, nonempty;
    ent_t ent, head;
    res_t res;

    assign s_ready = !full;
    assign in_ok   = s_valid && !full;

    sts_front #(.MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_ok   (in_ok),
        .ch      (s_ch),
        .eoi     (s_end_of_input),
        .push    (push),
        .ent     (ent)
    );

    sts_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wdata    (ent),
        .full     (full),
        .pop      (pop),
        .nonempty (nonempty),
        .rdata    (head)
    );

    sts_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_v   (nonempty),
        .head     (head),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .out_res  (res),
        .out_last (m_last)
    );

    assign m_token_kind   = res.kind;
    assign m_int_value    = res.value;
    assign m_bucket       = res.bucket;
    assign m_error_code   = res.err;
    assign m_start_line   = res.line;
    assign m_start_column = res.col;

endmodule

[test/tb_top.sv]
// Self-checking bench for source_token_scanner_top: a byte-level token predictor
// and scoreboard, with handshake drivers and a monitor. Depends on sts_pkg.
`timescale 1ns / 1ps

module tb_top;
    import sts_pkg::*;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int TOKEN_CAP       = 256;

    typedef struct {
        bit [8:0]  kind;
        bit [63:0] value;
        bit [9:0]  bucket;
        bit [2:0]  err;
        bit [23:0] line;
        bit [15:0] col;
        bit        last;
    } token_t;

    typedef struct {
        bit [7:0] ch;
        bit       eoi;
    } src_req_t;

    // Token predictor and expected-token store
    class token_scoreboard;
        mode_t           scan_st;
        bit [7:0]        op_lead;
        bit [63:0]       num_acc;
        int unsigned     base;
        bit [1:0]        base_fault;
        bit [9:0]        sym_hash;
        int unsigned     tok_len;
        bit [23:0]       cur_line;
        bit [15:0]       cur_col;
        bit [23:0]       tok_line;
        bit [15:0]       tok_col;
        token_t          pending_tokens[$];
        token_t          step_toks[$];
        int              mismatches;

        function void clear_state();
            scan_st    = M_IDLE;
            op_lead    = 0;
            num_acc    = 0;
            base       = 10;
            base_fault = FAULT_NONE;
            sym_hash   = 0;
            tok_len    = 0;
            cur_line   = 1;
            cur_col    = 0;
            tok_line   = 1;
            tok_col    = 0;
        endfunction

        function bit dec_ch(bit [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit word_ch(bit [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c > 8'ha0;
        endfunction

        function int unsigned weight(bit [7:0] c);
            if (dec_ch(c)) return c - "0";
            if (c >= "a" && c <= "z") return c - "a" + 10;
            if (c >= "A" && c <= "Z") return c - "A" + 10;
            return c;
        endfunction

        function void mix(bit [7:0] c);
            bit [31:0] c32;
            bit [31:0] c1;
            bit [31:0] h;
            c32 = c;
            c1 = c32 ^ (c32 << 6);
            h = sym_hash;
            h = h + ((c1 << 11) ^ (c1 >> 1));
            h = h ^ ((c32 << 14) + (c32 << 7) + (c32 << 4) + c32);
            sym_hash = h[9:0];
        endfunction

        // 0: no pair, 1: maybe a third char, else operator code
        function bit [8:0] pair_code(bit [7:0] f, bit [7:0] c);
            case (f)
                ":": return c == ":" ? OP_SCOPE : c == "=" ? OP_ASSIGN : PAIR_NONE;
                "|": return c == "=" ? OP_OR_EQ : c == "|" ? OP_LOR : PAIR_NONE;
                "&": return c == "=" ? OP_AND_EQ : c == "&" ? OP_LAND : PAIR_NONE;
                "^": return c == "=" ? OP_XOR_EQ : PAIR_NONE;
                "*": return c == "=" ? OP_MUL_EQ : c == "*" ? PAIR_THREE : PAIR_NONE;
                "/": return c == "=" ? OP_DIV_EQ : PAIR_NONE;
                "%": return c == "=" ? OP_MOD_EQ : PAIR_NONE;
                "=": return c == "=" ? OP_EQ : c == ">" ? OP_FATARROW : PAIR_NONE;
                "!": return c == "=" ? OP_NE : PAIR_NONE;
                ">": return c == "=" ? OP_GE : c == ">" ? PAIR_THREE : PAIR_NONE;
                "<": return c == "=" ? OP_LE : c == "-" ? OP_RECV :
                            c == "<" ? PAIR_THREE : PAIR_NONE;
                "+": return c == "=" ? OP_ADD_EQ : c == "+" ? OP_INC : PAIR_NONE;
                "-": return c == "=" ? OP_SUB_EQ : c == "-" ? OP_DEC :
                            c == ">" ? OP_ARROW : PAIR_NONE;
                default: return PAIR_NONE;
            endcase
        endfunction

        function bit [8:0] two_code(bit [7:0] f);
            return f == "*" ? OP_POW : f == ">" ? OP_RSH : OP_LSH;
        endfunction

        function bit [8:0] three_code(bit [7:0] f);
            return f == "*" ? OP_POW_EQ : f == ">" ? OP_RSH_EQ : OP_LSH_EQ;
        endfunction

        function void emit_pos(bit [8:0] k, bit [63:0] v, bit [9:0] b, bit [2:0] e,
                               bit [23:0] l, bit [15:0] c);
            token_t t;
            if (step_toks.size() >= 2) return;
            t.kind = k;
            t.value = (e != ERR_OK) ? 64'd0 : v;
            t.bucket = b;
            t.err = e;
            t.line = l;
            t.col = c;
            t.last = 0;
            step_toks.push_back(t);
        endfunction

        function void emit(bit [8:0] k, bit [63:0] v, bit [9:0] b, bit [2:0] e);
            emit_pos(k, v, b, e, tok_line, tok_col);
        endfunction

        function void begin_token(bit [7:0] c);
            tok_line = cur_line;
            tok_col = cur_col;
            case (c)
                8'h0a, " ", 8'h09, 8'h0d, 8'h0b, 8'h0c: return;
                "#": begin scan_st = M_COMMENT; return; end
                8'h22, 8'h27: begin emit(c, 0, 0, ERR_LITERAL); return; end
                "(", ")", "[", "]", "{", "}", ",", ";", "~": begin
                    emit(c, 0, 0, ERR_OK);
                    return;
                end
                ":", "|", "&", "^", "*", "/", "%", "=", "!", ">", "<", "+", "-": begin
                    op_lead = c;
                    scan_st = M_OP1;
                    return;
                end
                ".": begin tok_len = 1; scan_st = M_DOT; return; end
                default: ;
            endcase
            if (dec_ch(c)) begin
                num_acc = c - "0";
                base_fault = FAULT_NONE;
                base = 10;
                tok_len = 1;
                scan_st = M_INT;
            end else if (word_ch(c)) begin
                sym_hash = 0;
                mix(c);
                tok_len = 1;
                scan_st = M_IDENT;
            end else begin
                emit(c, 0, 0, ERR_UNKNOWN);
            end
        endfunction

        function void base_digit(bit [7:0] c, bit kept);
            int unsigned d;
            if (!kept || base_fault != FAULT_NONE) return;
            d = weight(c);
            if (d >= base) base_fault = FAULT_DIGIT;
            else num_acc = num_acc * base + d;
        endfunction

        // True when the byte extends the number
        function bit extend_number(bit [7:0] c);
            bit kept;
            bit alnum;
            bit took;
            kept = tok_len < TOKEN_CAP - 1;
            alnum = dec_ch(c) || word_ch(c);
            took = 0;
            case (scan_st)
                M_INT: begin
                    if (dec_ch(c)) begin
                        if (kept) begin
                            num_acc = num_acc * 10 + (c - "0");
                            if (num_acc > 36) base_fault = FAULT_RADIX;
                        end
                        took = 1;
                    end else if (c == "e" || c == "E") begin
                        scan_st = M_EXPSEEN; took = 1;
                    end else if (c == "r" || c == "R") begin
                        if (base_fault != FAULT_NONE || num_acc < 2) base_fault = FAULT_RADIX;
                        else begin base = 32'(num_acc); base_fault = FAULT_NONE; end
                        num_acc = 0;
                        scan_st = M_RSEEN; took = 1;
                    end else if (c == ".") begin
                        scan_st = M_FRAC; took = 1;
                    end
                end
                M_RSEEN, M_RADIX: begin
                    if (alnum) begin
                        base_digit(c, kept); scan_st = M_RADIX; took = 1;
                    end else if (c == ".") begin
                        scan_st = M_FRACB; took = 1;
                    end
                end
                M_FRACB: if (alnum) begin base_digit(c, kept); took = 1; end
                M_FRAC: begin
                    if (dec_ch(c)) took = 1;
                    else if (c == "e" || c == "E") begin scan_st = M_EXPSEEN; took = 1; end
                end
                M_EXPSEEN: begin
                    if (c == "+" || c == "-") begin scan_st = M_EXPSIGN; took = 1; end
                    else if (dec_ch(c)) begin scan_st = M_EXP; took = 1; end
                end
                default: if (dec_ch(c)) begin scan_st = M_EXP; took = 1; end
            endcase
            if (took && tok_len < TOKEN_CAP) tok_len++;
            return took;
        endfunction

        function void close_number();
            case (scan_st)
                M_INT: emit(K_INT, num_acc, 0, ERR_OK);
                M_RADIX: begin
                    if (base_fault == FAULT_RADIX) emit(K_INT, 0, 0, ERR_RADIX);
                    else if (base_fault == FAULT_DIGIT) emit(K_INT, 0, 0, ERR_DIGIT);
                    else emit(K_INT, num_acc, 0, ERR_OK);
                end
                M_FRACB: begin
                    if (base_fault == FAULT_RADIX) emit(K_INT, 0, 0, ERR_RADIX);
                    else emit(K_REAL, 0, 0, base_fault == FAULT_DIGIT ? ERR_DIGIT : ERR_OK);
                end
                M_FRAC, M_EXP: emit(K_REAL, 0, 0, ERR_OK);
                default: emit(K_INT, 0, 0, ERR_MALFORMED);
            endcase
        endfunction

        // Predict the tokens of one accepted request
        function void note_request(bit [7:0] c, bit eoi);
            bit used;
            bit [8:0] pc;
            used = 0;
            step_toks.delete();
            if (eoi) begin
                case (scan_st)
                    M_IDLE, M_COMMENT: ;
                    M_OP1: emit(op_lead, 0, 0, ERR_OK);
                    M_OP2: emit(two_code(op_lead), 0, 0, ERR_OK);
                    M_DOT: emit(".", 0, 0, ERR_OK);
                    M_IDENT: emit(K_IDENT, 0, sym_hash, ERR_OK);
                    default: emit(K_END, 0, 0, ERR_EOF_NUM);
                endcase
                if (step_toks.size() == 0 || step_toks[0].kind != K_END)
                    emit_pos(K_END, 0, 0, ERR_OK, cur_line, cur_col);
                clear_state();
            end else begin
                case (scan_st)
                    M_IDLE: ;
                    M_COMMENT: begin
                        if (c == 8'h0a) scan_st = M_IDLE;
                        used = 1;
                    end
                    M_OP1: begin
                        pc = pair_code(op_lead, c);
                        if (pc >= 256) begin
                            emit(pc, 0, 0, ERR_OK); scan_st = M_IDLE; used = 1;
                        end else if (pc == PAIR_THREE) begin
                            scan_st = M_OP2; used = 1;
                        end else begin
                            emit(op_lead, 0, 0, ERR_OK); scan_st = M_IDLE;
                        end
                    end
                    M_OP2: begin
                        if (c == "=") begin
                            emit(three_code(op_lead), 0, 0, ERR_OK); used = 1;
                        end else emit(two_code(op_lead), 0, 0, ERR_OK);
                        scan_st = M_IDLE;
                    end
                    M_DOT: begin
                        if (dec_ch(c)) begin scan_st = M_FRAC; tok_len = 2; used = 1; end
                        else begin emit(".", 0, 0, ERR_OK); scan_st = M_IDLE; end
                    end
                    M_IDENT: begin
                        if (dec_ch(c) || word_ch(c)) begin
                            if (tok_len < TOKEN_CAP) begin mix(c); tok_len++; end
                            used = 1;
                        end else begin
                            emit(K_IDENT, 0, sym_hash, ERR_OK); scan_st = M_IDLE;
                        end
                    end
                    default: begin
                        used = extend_number(c);
                        if (!used) begin close_number(); scan_st = M_IDLE; end
                    end
                endcase
                if (!used) begin_token(c);
                // Advance the position counters
                if (c == 8'h0a) begin
                    if (cur_line != 24'hffffff) cur_line++;
                    cur_col = 0;
                end else if (cur_col != 16'hffff) cur_col++;
            end
            if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1;
            foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
        endfunction

        task report(string field, bit [63:0] got, bit [63:0] want);
            $display("mismatch %s: got %0h expected %0h", field, got, want);
            mismatches++;
        endtask

        task check_token(token_t got);
            token_t want;
            if (pending_tokens.size() == 0) begin
                report("unexpected token kind", got.kind, 0);
                return;
            end
            want = pending_tokens.pop_front();
            if (got.kind != want.kind) report("kind", got.kind, want.kind);
            if (got.value != want.value) report("value", got.value, want.value);
            if (got.bucket != want.bucket) report("bucket", got.bucket, want.bucket);
            if (got.err != want.err) report("error", got.err, want.err);
            if (got.line != want.line) report("line", got.line, want.line);
            if (got.col != want.col) report("column", got.col, want.col);
            if (got.last != want.last) report("last", got.last, want.last);
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_ch;
    logic                 s_end_of_input;
    logic                 m_valid;
    logic                 m_ready;
    logic [KIND_BITS-1:0] m_token_kind;
    logic [63:0]          m_int_value;
    logic [HASH_BITS-1:0] m_bucket;
    logic [ERR_BITS-1:0]  m_error_code;
    logic [LINE_BITS-1:0] m_start_line;
    logic [COL_BITS-1:0]  m_start_column;
    logic                 m_last;

    token_scoreboard sb;
    src_req_t        source_text[$];
    int              src_idle_pct;
    int              sink_idle_pct;
    int              quiet_cycles;

    source_token_scanner_top i_dut (.*);

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Note requests, check tokens, and watch for a stuck handshake
    always @(posedge aclk) begin
        token_t got;
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_request(s_ch, s_end_of_input);
            if (m_valid && m_ready) begin
                got.kind = m_token_kind;
                got.value = m_int_value;
                got.bucket = m_bucket;
                got.err = m_error_code;
                got.line = m_start_line;
                got.col = m_start_column;
                got.last = m_last;
                sb.check_token(got);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Stall the token side at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function void add_ch(bit [7:0] c);
        src_req_t r;
        r.ch = c;
        r.eoi = 0;
        source_text.push_back(r);
    endfunction

    function void add_str(string s);
        foreach (s[i]) add_ch(s[i]);
    endfunction

    function void add_end();
        src_req_t r;
        r.ch = 8'($urandom_range(255));
        r.eoi = 1;
        source_text.push_back(r);
    endfunction

    function bit [7:0] pick(string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    // Build one random lexeme, mostly well formed
    function void add_lexeme();
        string word_set;
        string alnum_set;
        string op_set;
        int n;
        word_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        alnum_set = {word_set, "0123456789"};
        op_set = ":|&^*/%=!><+-";
        case ($urandom_range(11))
            0, 1: begin
                add_ch($urandom_range(1) ? pick(word_set) : 8'(161 + $urandom_range(94)));
                n = $urandom_range(7);
                repeat (n) add_ch($urandom_range(7) == 0 ? 8'(161 + $urandom_range(94))
                                                        : pick(alnum_set));
            end
            2: begin
                n = $urandom_range(1, 22);
                repeat (n) add_ch(pick("0123456789"));
            end
            3: begin
                add_str($sformatf("%0d", $urandom_range(40)));
                add_ch(pick("rR"));
                n = $urandom_range(6);
                repeat (n) add_ch(pick(alnum_set));
                if ($urandom_range(3) == 0) begin
                    add_ch(".");
                    n = $urandom_range(3);
                    repeat (n) add_ch(pick(alnum_set));
                end
            end
            4: begin
                if ($urandom_range(1)) add_str($sformatf("%0d", $urandom_range(999)));
                add_ch(".");
                n = $urandom_range(3);
                repeat (n) add_ch(pick("0123456789"));
                if ($urandom_range(1)) begin
                    add_ch(pick("eE"));
                    if ($urandom_range(1)) add_ch(pick("+-"));
                    n = $urandom_range(2);
                    repeat (n) add_ch(pick("0123456789"));
                end
            end
            5, 6: begin
                n = $urandom_range(1, 3);
                repeat (n) add_ch(pick(op_set));
            end
            7: add_ch(pick("()[]{},;~\"'.@$`?\\"));
            8: begin
                add_ch("#");
                n = $urandom_range(5);
                repeat (n) add_ch(8'($urandom_range(255)));
                add_ch(8'h0a);
            end
            9: add_ch(pick(" \t\r\n"));
            10: add_ch(8'($urandom_range(255)));
            default: if ($urandom_range(3) == 0) add_end();
        endcase
        if ($urandom_range(2) == 0) add_ch(pick(" \n"));
    endfunction

    task send_request(src_req_t r);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_ch <= r.ch;
        s_end_of_input <= r.eoi;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        int total;
        sb = new();
        sb.clear_state();
        sb.mismatches = 0;
        quiet_cycles = 0;
        src_idle_pct = 35;
        sink_idle_pct = 75;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_ch = 8'd0;
        s_end_of_input = 1'b0;
        m_ready = 1'b0;

        // Directed: three-char operator, radix real, malformed exponent,
        // literal quote, comment, unknown byte, bad radix ended inside a number
        add_str("<<=x9 36r.z 1e+ 'Z@#\n");
        add_end();
        add_str("37r1");
        add_end();

        // Identifier and radix number longer than the token cap
        repeat (258) add_ch("q");
        add_ch(" ");
        add_str("16r");
        repeat (256) add_ch("f");
        add_ch(" ");

        // Random source
        while (source_text.size() < 700) add_lexeme();
        add_end();
        total = source_text.size();

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < total; i++) begin
            if (i == total / 3) begin
                src_idle_pct = 75;
                sink_idle_pct = 35;
            end
            if (i == 2 * total / 3) begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            send_request(source_text[i]);
        end
        s_valid <= 1'b0;

        while (sb.pending_tokens.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

[source_token_scanner_top.f]
+incdir+hdl
hdl/sts_pkg.sv
hdl/sts_front.sv
hdl/sts_fifo.sv
hdl/sts_back.sv
hdl/source_token_scanner_top.sv
test/tb_top.sv
